/* hw/rtl/evdw_pkg.sv */
// Shared types and constants for the event duration window statistics unit.
package evdw_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MIN_DURATION  = 3'd0;
    localparam logic [2:0] REG_MAX_DURATION  = 3'd1;
    localparam logic [2:0] REG_SHORT_WINDOW  = 3'd2;
    localparam logic [2:0] REG_MEDIUM_WINDOW = 3'd3;
    localparam logic [2:0] REG_LONG_WINDOW   = 3'd4;

    // Register reset values
    localparam logic [31:0] RST_MIN_DURATION  = 32'd5000;
    localparam logic [31:0] RST_MAX_DURATION  = 32'd60000;
    localparam logic [31:0] RST_SHORT_WINDOW  = 32'd86400000;
    localparam logic [31:0] RST_MEDIUM_WINDOW = 32'd604800000;
    localparam logic [31:0] RST_LONG_WINDOW   = 32'd2592000000;

    localparam int NUM_WIN = 3;

    // One ring entry: time stamp and low half of the duration
    typedef struct packed {
        logic [31:0] stamp;
        logic [15:0] length;
    } t_ring_entry;

    // Request to the shared divider
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_UPD  = 6'b000010,
        S_SCAN = 6'b000100,
        S_DIV  = 6'b001000,
        S_WAIT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

endpackage

/* hw/rtl/evdw_ring.sv */
// History ring memory: one write port, one read port with registered data.
module evdw_ring
    import evdw_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_ring_entry   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_ring_entry   o_rdata
);

    t_ring_entry r_mem [DEPTH];

    // Synchronous write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hw/rtl/evdw_div.sv */
// Restoring divider, one quotient bit per cycle, 32-bit operands.
module evdw_div
    import evdw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [15:0] o_quot
);

    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] rem_sh;
    logic [32:0] trial;

    // Shift in next dividend bit and try a subtract
    assign rem_sh = {r_rem, r_quo[31]};
    assign trial  = rem_sh - {1'b0, r_div};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= 32'd0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            if (!trial[32]) begin
                r_rem <= trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo[15:0];

endmodule

/* hw/rtl/event_duration_window_statistics_unit.sv */
// Top level: statistics registers, ring scan sequencer and output register.
//
// Each transfer is handled alone: the statistics are updated and the ring is
// written (S_UPD), then one read per filled ring entry is issued to the single
// read port and the registered read data is accumulated (S_SCAN), then four
// division jobs run on the shared bit-serial divider (S_DIV, S_WAIT), a job
// being skipped when its count is zero or no record was accepted, then the
// output register is loaded (S_OUT). The load waits while the previous result
// is still held, and the input is ready again in the cycle after the load.
// The ring needs no clearing after reset; only entries already written are
// scanned. A new transfer is taken while the previous result still waits in
// the output register.
module event_duration_window_statistics_unit
    import evdw_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    // Input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,  // duration[31:0], now_time[63:32]
    input  logic [1:0]   i_s_axis_tuser,  // operation[1:0]
    // Output stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // event_count[31:0], time_sum[63:32], mean_time[79:64], least_time[95:80],
    // most_time[111:96], short_count[118:112], short_mean[134:119],
    // medium_count[141:135], medium_mean[157:142], long_count[164:158],
    // long_mean[180:165], zero[183:181]
    output logic [183:0] o_m_axis_tdata,
    output logic         o_m_axis_tuser   // accepted
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = 16 + CW;

    // Configuration
    logic [31:0] r_min_dur, r_max_dur;
    logic [31:0] r_win [NUM_WIN];

    // Statistics
    logic [31:0]   r_tot_ev, r_tot_time;
    logic [15:0]   r_mean, r_min, r_max;
    logic [AW-1:0] r_wslot;
    logic [CW-1:0] r_filled;

    // Operation in progress
    t_state      r_state;
    logic [1:0]  r_op;
    logic [31:0] r_dur, r_now;
    logic        r_acc;
    logic        r_do_mean;

    // Scan
    logic [CW-1:0] r_issue;
    logic          r_pv;
    logic [CW-1:0] r_cnt [NUM_WIN];
    logic [SW-1:0] r_sum [NUM_WIN];
    logic [1:0]    r_job;
    logic [15:0]   r_wmean [NUM_WIN];

    // Output register
    logic         r_out_valid;
    logic [183:0] r_out_data;
    logic         r_out_acc;

    // Ring and divider connections
    logic        ring_we;
    t_ring_entry ring_wdata, ring_rdata;
    t_div_req    div_req;
    logic        div_done;
    logic [15:0] div_quot;

    logic        in_xfer, out_xfer, out_load, in_range, job_need;
    logic [31:0] upd_cnt, upd_time, diff;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = r_out_valid && i_m_axis_tready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);
    assign in_range = (r_dur >= r_min_dur) && (r_dur <= r_max_dur);
    assign upd_cnt  = r_tot_ev + 32'd1;
    assign upd_time = r_tot_time + r_dur;
    assign diff     = r_now - ring_rdata.stamp;

    assign ring_we          = (r_state == S_UPD) && (r_op == OP_RECORD) && in_range;
    assign ring_wdata.stamp  = r_now;
    assign ring_wdata.length = r_dur[15:0];

    evdw_ring #(.DEPTH(HISTORY_DEPTH), .AW(AW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wslot),
        .i_wdata (ring_wdata),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (ring_rdata)
    );

    // Division job select: overall mean, then the three window means
    always_comb begin
        job_need         = 1'b0;
        div_req.dividend = r_tot_time;
        div_req.divisor  = r_tot_ev;
        unique case (r_job)
            2'd0: job_need = r_do_mean;
            2'd1: begin
                job_need         = (r_cnt[0] != '0);
                div_req.dividend = 32'(r_sum[0]);
                div_req.divisor  = 32'(r_cnt[0]);
            end
            2'd2: begin
                job_need         = (r_cnt[1] != '0);
                div_req.dividend = 32'(r_sum[1]);
                div_req.divisor  = 32'(r_cnt[1]);
            end
            default: begin
                job_need         = (r_cnt[2] != '0);
                div_req.dividend = 32'(r_sum[2]);
                div_req.divisor  = 32'(r_cnt[2]);
            end
        endcase
        div_req.start = (r_state == S_DIV) && job_need;
    end

    evdw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dur <= RST_MIN_DURATION;
            r_max_dur <= RST_MAX_DURATION;
            r_win[0]  <= RST_SHORT_WINDOW;
            r_win[1]  <= RST_MEDIUM_WINDOW;
            r_win[2]  <= RST_LONG_WINDOW;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_MIN_DURATION:  r_min_dur <= i_cfg_data;
                REG_MAX_DURATION:  r_max_dur <= i_cfg_data;
                REG_SHORT_WINDOW:  r_win[0]  <= i_cfg_data;
                REG_MEDIUM_WINDOW: r_win[1]  <= i_cfg_data;
                REG_LONG_WINDOW:   r_win[2]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tot_ev   <= '0;
            r_tot_time <= '0;
            r_mean     <= '0;
            r_min      <= '0;
            r_max      <= '0;
            r_wslot    <= '0;
            r_filled   <= '0;
            r_pv       <= 1'b0;
            r_issue    <= '0;
            r_job      <= '0;
            r_acc      <= 1'b0;
            r_do_mean  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_op    <= i_s_axis_tuser;
                        r_dur   <= i_s_axis_tdata[31:0];
                        r_now   <= i_s_axis_tdata[63:32];
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_acc     <= 1'b0;
                    r_do_mean <= 1'b0;
                    if (r_op == OP_RECORD && in_range) begin
                        r_acc      <= 1'b1;
                        r_do_mean  <= (upd_cnt != 32'd0);
                        r_tot_ev   <= upd_cnt;
                        r_tot_time <= upd_time;
                        if (upd_cnt == 32'd1) begin
                            r_min <= r_dur[15:0];
                            r_max <= r_dur[15:0];
                        end else begin
                            if (r_dur < {16'd0, r_min}) r_min <= r_dur[15:0];
                            if (r_dur > {16'd0, r_max}) r_max <= r_dur[15:0];
                        end
                        r_wslot <= (r_wslot == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                       : r_wslot + AW'(1);
                        if (r_filled < CW'(HISTORY_DEPTH)) r_filled <= r_filled + CW'(1);
                    end else if (r_op == OP_CLEAR) begin
                        r_tot_ev   <= '0;
                        r_tot_time <= '0;
                        r_mean     <= '0;
                        r_min      <= '0;
                        r_max      <= '0;
                        r_wslot    <= '0;
                        r_filled   <= '0;
                    end
                    for (int w = 0; w < NUM_WIN; w++) begin
                        r_cnt[w] <= '0;
                        r_sum[w] <= '0;
                    end
                    r_issue <= '0;
                    r_pv    <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // Issue one read a cycle, accumulate its data in the next cycle
                    if (r_issue < r_filled) begin
                        r_issue <= r_issue + CW'(1);
                        r_pv    <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && (r_now >= ring_rdata.stamp)) begin
                        for (int w = 0; w < NUM_WIN; w++) begin
                            if (diff <= r_win[w]) begin
                                r_cnt[w] <= r_cnt[w] + CW'(1);
                                r_sum[w] <= r_sum[w] + SW'(ring_rdata.length);
                            end
                        end
                    end
                    if (r_issue == r_filled && !r_pv) begin
                        r_job   <= 2'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (job_need) begin
                        r_state <= S_WAIT;
                    end else begin
                        if (r_job != 2'd0) r_wmean[r_job - 2'd1] <= 16'd0;
                        if (r_job == 2'd3) r_state <= S_OUT;
                        r_job <= r_job + 2'd1;
                    end
                end
                S_WAIT: begin
                    if (div_done) begin
                        if (r_job == 2'd0) r_mean <= div_quot;
                        else               r_wmean[r_job - 2'd1] <= div_quot;
                        r_state <= (r_job == 2'd3) ? S_OUT : S_DIV;
                        r_job   <= r_job + 2'd1;
                    end
                end
                S_OUT: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [CW+6:0] c0, c1, c2;
        c0 = {7'd0, r_cnt[0]};
        c1 = {7'd0, r_cnt[1]};
        c2 = {7'd0, r_cnt[2]};
        if (out_load) begin
            r_out_acc  <= r_acc;
            r_out_data <= {3'd0, r_wmean[2], c2[6:0], r_wmean[1], c1[6:0],
                           r_wmean[0], c0[6:0], r_max, r_min, r_mean,
                           r_tot_time, r_tot_ev};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_acc;

endmodule

/* hw/rtl/evdw_checker.sv */
// Port-level checks for the statistics unit, bound to the top level.
module evdw_port_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [183:0] o_m_axis_tdata
);

    // One operation at a time: ready drops right after a transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while an operation is in progress");

    // A waiting result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result lost before transfer");

    // Empty short window reports zero mean
    a_short_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[118:112] == 7'd0)
        |-> o_m_axis_tdata[134:119] == 16'd0)
        else $error("short mean nonzero with zero count");

    // Empty long window reports zero mean
    a_long_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[164:158] == 7'd0)
        |-> o_m_axis_tdata[180:165] == 16'd0)
        else $error("long mean nonzero with zero count");

endmodule

bind event_duration_window_statistics_unit evdw_port_checker u_evdw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* tb/sv/evdw_checker.sv */
// Checker for the event duration window statistics unit: watches both streams and compares.
module evdw_checker
    import evdw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [63:0]  i_s_tdata,
    input  logic [1:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [183:0] i_m_tdata,
    input  logic         i_m_tuser,
    output int           o_errors,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] long_mean;
        logic [6:0]  long_count;
        logic [15:0] medium_mean;
        logic [6:0]  medium_count;
        logic [15:0] short_mean;
        logic [6:0]  short_count;
        logic [15:0] most_time;
        logic [15:0] least_time;
        logic [15:0] mean_time;
        logic [31:0] time_sum;
        logic [31:0] event_count;
    } t_stats;

    typedef struct packed {
        logic   accepted;
        t_stats stats;
    } t_result;

    // Model state and registers
    logic [31:0] min_dur, max_dur;
    logic [31:0] win_len [NUM_WIN];
    logic [31:0] n_events, sum_time;
    logic [15:0] mean_q, least_q, most_q;
    logic [31:0] stamps [DEPTH];
    logic [15:0] lengths [DEPTH];
    int          slot, filled;
    t_result     stats_queue [$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = stats_queue.size();

    // Apply one operation to the model state and return its statistics
    function automatic t_result apply_op(logic [1:0] op, logic [31:0] dur, logic [31:0] now);
        t_result     r;
        logic [31:0] cnt [NUM_WIN];
        logic [31:0] acc_sum [NUM_WIN];
        r = '0;
        if (op == OP_RECORD && dur >= min_dur && dur <= max_dur) begin
            r.accepted = 1'b1;
            n_events = n_events + 1;
            sum_time = sum_time + dur;
            if (n_events != 0) mean_q = 16'(sum_time / n_events);
            if (n_events == 1) begin
                least_q = dur[15:0];
                most_q  = dur[15:0];
            end else begin
                if (dur < {16'd0, least_q}) least_q = dur[15:0];
                if (dur > {16'd0, most_q})  most_q  = dur[15:0];
            end
            stamps[slot]  = now;
            lengths[slot] = dur[15:0];
            slot = (slot + 1) % DEPTH;
            if (filled < DEPTH) filled++;
        end else if (op == OP_CLEAR) begin
            n_events = 0; sum_time = 0; mean_q = 0; least_q = 0; most_q = 0;
            slot = 0; filled = 0;
        end
        for (int w = 0; w < NUM_WIN; w++) begin
            cnt[w] = 0;
            acc_sum[w] = 0;
        end
        // Window scan over the filled entries; future stamps are skipped
        for (int i = 0; i < filled; i++) begin
            if (now >= stamps[i]) begin
                for (int w = 0; w < NUM_WIN; w++) begin
                    if (now - stamps[i] <= win_len[w]) begin
                        cnt[w]++;
                        acc_sum[w] += lengths[i];
                    end
                end
            end
        end
        r.stats.event_count  = n_events;
        r.stats.time_sum     = sum_time;
        r.stats.mean_time    = mean_q;
        r.stats.least_time   = least_q;
        r.stats.most_time    = most_q;
        r.stats.short_count  = cnt[0][6:0];
        r.stats.short_mean   = cnt[0] != 0 ? 16'(acc_sum[0] / cnt[0]) : 16'd0;
        r.stats.medium_count = cnt[1][6:0];
        r.stats.medium_mean  = cnt[1] != 0 ? 16'(acc_sum[1] / cnt[1]) : 16'd0;
        r.stats.long_count   = cnt[2][6:0];
        r.stats.long_mean    = cnt[2] != 0 ? 16'(acc_sum[2] / cnt[2]) : 16'd0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic compare_result(t_result got, t_result want);
        if (got.accepted != want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
        if (got.stats.event_count != want.stats.event_count)
            report_mismatch("event_count", got.stats.event_count, want.stats.event_count);
        if (got.stats.time_sum != want.stats.time_sum)
            report_mismatch("time_sum", got.stats.time_sum, want.stats.time_sum);
        if (got.stats.mean_time != want.stats.mean_time)
            report_mismatch("mean_time", got.stats.mean_time, want.stats.mean_time);
        if (got.stats.least_time != want.stats.least_time)
            report_mismatch("least_time", got.stats.least_time, want.stats.least_time);
        if (got.stats.most_time != want.stats.most_time)
            report_mismatch("most_time", got.stats.most_time, want.stats.most_time);
        if (got.stats.short_count != want.stats.short_count)
            report_mismatch("short_count", got.stats.short_count, want.stats.short_count);
        if (got.stats.short_mean != want.stats.short_mean)
            report_mismatch("short_mean", got.stats.short_mean, want.stats.short_mean);
        if (got.stats.medium_count != want.stats.medium_count)
            report_mismatch("medium_count", got.stats.medium_count,
                            want.stats.medium_count);
        if (got.stats.medium_mean != want.stats.medium_mean)
            report_mismatch("medium_mean", got.stats.medium_mean, want.stats.medium_mean);
        if (got.stats.long_count != want.stats.long_count)
            report_mismatch("long_count", got.stats.long_count, want.stats.long_count);
        if (got.stats.long_mean != want.stats.long_mean)
            report_mismatch("long_mean", got.stats.long_mean, want.stats.long_mean);
        if (got.stats.pad != 3'd0)
            report_mismatch("padding", got.stats.pad, 0);
    endtask

    // Track configuration, inputs and outputs at each rising edge
    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            min_dur = RST_MIN_DURATION;
            max_dur = RST_MAX_DURATION;
            win_len[0] = RST_SHORT_WINDOW;
            win_len[1] = RST_MEDIUM_WINDOW;
            win_len[2] = RST_LONG_WINDOW;
            n_events = 0; sum_time = 0; mean_q = 0; least_q = 0; most_q = 0;
            slot = 0; filled = 0;
            stats_queue.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_MIN_DURATION:  min_dur = i_cfg_data;
                    REG_MAX_DURATION:  max_dur = i_cfg_data;
                    REG_SHORT_WINDOW:  win_len[0] = i_cfg_data;
                    REG_MEDIUM_WINDOW: win_len[1] = i_cfg_data;
                    REG_LONG_WINDOW:   win_len[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.accepted = i_m_tuser;
                got.stats    = i_m_tdata;
                if (stats_queue.size() == 0) begin
                    $display("unexpected result transfer at %0t", $realtime);
                    errors++;
                end else begin
                    compare_result(got, stats_queue.pop_front());
                end
            end
            if (i_s_tvalid && i_s_tready)
                stats_queue.push_back(apply_op(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32]));
        end
    end

    initial errors = 0;

endmodule

/* tb/sv/testbench.sv */
// Top of the testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import evdw_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [63:0]  i_s_axis_tdata = '0;
    logic [1:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [183:0] o_m_axis_tdata;
    logic         o_m_axis_tuser;
    int           errors, pending;
    int           idle_cycles = 0;
    bit           quiet_tail = 0;
    bit           hold_off = 0;
    logic [31:0]  clock_ms = 32'd0;

    localparam int WATCHDOG = 20000;

    always #5 i_clk = ~i_clk;

    event_duration_window_statistics_unit dut (.*);

    evdw_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_index, .i_cfg_data,
        .i_s_tvalid(i_s_axis_tvalid), .i_s_tready(o_s_axis_tready),
        .i_s_tdata(i_s_axis_tdata), .i_s_tuser(i_s_axis_tuser),
        .i_m_tvalid(o_m_axis_tvalid), .i_m_tready(i_m_axis_tready),
        .i_m_tdata(o_m_axis_tdata), .i_m_tuser(o_m_axis_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    // Watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_m_axis_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 4);
                i_m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Write enable stays high across a series of writes; the next send drops it
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Stop offering, wait for every result, then let the block settle
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic send_op(logic [1:0] op, logic [31:0] dur, logic [31:0] now);
        int n;
        i_cfg_wr_en <= 1'b0;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 4);
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {now, dur};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Mostly in-range durations at advancing times, some noise
    task automatic random_op(logic [31:0] lo, logic [31:0] hi);
        int          pick;
        logic [1:0]  op;
        logic [31:0] dur;
        pick = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, 40000000);
        if (pick < 75) op = OP_RECORD;
        else if (pick < 90) op = OP_QUERY;
        else if (pick < 93) op = OP_CLEAR;
        else op = 2'd3;
        if ($urandom_range(0, 9) < 8) dur = lo + ($urandom % (hi - lo + 1));
        else dur = $urandom;
        if ($urandom_range(0, 19) == 0) send_op(op, dur, $urandom);
        else send_op(op, dur, clock_ms);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults, field extremes, each operation
        send_op(OP_QUERY, 32'd0, 32'd0);
        send_op(OP_RECORD, 32'd4999, 32'd1000);
        send_op(OP_RECORD, 32'd5000, 32'd1000);
        send_op(OP_RECORD, 32'd60000, 32'd2000);
        send_op(OP_RECORD, 32'd60001, 32'd3000);
        send_op(OP_RECORD, 32'd30000, 32'd500);
        send_op(OP_QUERY, 32'hFFFF_FFFF, 32'd900);
        send_op(2'd3, 32'd0, 32'd86401000);
        send_op(OP_QUERY, 32'd0, 32'd86400500);
        send_op(OP_QUERY, 32'd0, 32'hFFFF_FFFF);
        send_op(OP_CLEAR, 32'd0, 32'd5000);
        send_op(OP_QUERY, 32'd0, 32'd5000);
        drain();

        // Wide-open range: full-width durations, zero, one and full-width windows
        write_reg(REG_MIN_DURATION, 32'd0);
        write_reg(REG_MAX_DURATION, 32'hFFFF_FFFF);
        write_reg(REG_SHORT_WINDOW, 32'd0);
        write_reg(REG_MEDIUM_WINDOW, 32'd1);
        write_reg(REG_LONG_WINDOW, 32'hFFFF_FFFF);
        send_op(OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_RECORD, 32'd0, 32'hFFFF_FFFE);
        send_op(OP_RECORD, 32'h0001_0002, 32'd0);
        send_op(OP_RECORD, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_QUERY, 32'd0, 32'hFFFF_FFFF);
        send_op(OP_QUERY, 32'd0, 32'd0);
        for (int i = 0; i < 300; i++) random_op(32'd0, 32'hFFFF_FFFE);

        // Long receiver hold-off while the sender keeps offering
        hold_off = 1;
        for (int i = 0; i < 10; i++) random_op(32'd0, 32'hFFFF_FFFE);
        drain();

        // Default-like setting with narrow windows
        write_reg(REG_MIN_DURATION, 32'd5000);
        write_reg(REG_MAX_DURATION, 32'd60000);
        write_reg(REG_SHORT_WINDOW, 32'd20000000);
        write_reg(REG_MEDIUM_WINDOW, 32'd200000000);
        write_reg(REG_LONG_WINDOW, 32'd2000000000);
        for (int i = 0; i < 400; i++) random_op(32'd5000, 32'd60000);
        drain();

        // Empty accept range, then defaults back
        write_reg(REG_MIN_DURATION, 32'hFFFF_FFFF);
        write_reg(REG_MAX_DURATION, 32'd0);
        for (int i = 0; i < 30; i++) random_op(32'd0, 32'd100);
        drain();
        write_reg(REG_MIN_DURATION, RST_MIN_DURATION);
        write_reg(REG_MAX_DURATION, RST_MAX_DURATION);
        write_reg(REG_SHORT_WINDOW, RST_SHORT_WINDOW);
        write_reg(REG_MEDIUM_WINDOW, RST_MEDIUM_WINDOW);
        write_reg(REG_LONG_WINDOW, RST_LONG_WINDOW);
        for (int i = 0; i < 550; i++) random_op(32'd5000, 32'd60000);
        quiet_tail = 1;
        for (int i = 0; i < 150; i++) random_op(32'd5000, 32'd60000);

        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/evdw_pkg.sv
hw/rtl/evdw_ring.sv
hw/rtl/evdw_div.sv
hw/rtl/event_duration_window_statistics_unit.sv
hw/rtl/evdw_checker.sv
tb/sv/evdw_checker.sv
tb/sv/testbench.sv
